[design/seven_segment_scan_driver_macros.svh]
// Assertion macros shared by the scan driver checker.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ssd_pkg.sv]
// Shared constants, types and the segment lookup of the scan driver.
package ssd_pkg;

    localparam int MAX_DIGITS  = 8;
    localparam int EXTRA_SLOTS = 4;
    localparam int STORE_DEPTH = MAX_DIGITS + EXTRA_SLOTS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PTR_W       = 5;
    // One more bit than the pointer so that pointer plus one never wraps.
    localparam int RD_AW       = PTR_W + 1;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 4;
    localparam int LINE_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int DWELL_W     = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TABLE_DEPTH = 46;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_FIRST   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_LAST    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [COUNT_W-1:0] RESET_DIGITS = 4'd4;
    localparam logic [DWELL_W-1:0] RESET_DWELL  = 16'd100;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIGIT_COUNT = 2'd0,
        CFG_ACTIVE_LOW  = 2'd1,
        CFG_DWELL_TICKS = 2'd2
    } t_cfg_addr;

    typedef logic [7:0] t_seg_table [TABLE_DEPTH];

    localparam t_seg_table SEG_TABLE = '{
        8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
        8'h76, 8'h30, 8'h0E, 8'h7A, 8'h38, 8'h55, 8'h54,
        8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h1C, 8'h6A, 8'h64, 8'h6E, 8'h5A
    };

    typedef struct packed {
        logic                en;
        logic [POS_W-1:0]    pos;
        logic [CHAR_W-1:0]   data;
    } t_wr_req;

    typedef struct packed {
        logic                en;
        logic [RD_AW-1:0]    addr0;
        logic [RD_AW-1:0]    addr1;
    } t_rd_req;

    typedef struct packed {
        logic [CHAR_W-1:0]   char0;
        logic [CHAR_W-1:0]   char1;
    } t_rd_rsp;

    // Lower case folds to upper case; codes outside the table are blank.
    function automatic logic [LINE_W-1:0] seg_lookup(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0]   u;
        logic [TABLE_AW-1:0] idx;
        u   = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? (c - CASE_OFFSET) : c;
        idx = TABLE_AW'(u - CHAR_FIRST);
        if (u < CHAR_FIRST || u > CHAR_LAST) begin
            return '0;
        end
        return SEG_TABLE[idx];
    endfunction

endpackage

[design/ssd_in_if.sv]
// Input item channel: write and tick commands.
interface ssd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [ssd_pkg::POS_W-1:0]    position;
    logic [ssd_pkg::CHAR_W-1:0]   char_code;

    modport source (output valid, cmd, position, char_code, input ready);
    modport sink   (input valid, cmd, position, char_code, output ready);
endinterface

[design/ssd_out_if.sv]
// Result item channel: one drive word per tick.
interface ssd_out_if;
    logic                         valid;
    logic                         ready;
    logic [ssd_pkg::LINE_W-1:0]   common_lines;
    logic [ssd_pkg::LINE_W-1:0]   segment_lines;
    logic                         pass_end;

    modport source (output valid, common_lines, segment_lines, pass_end, input ready);
    modport sink   (input valid, common_lines, segment_lines, pass_end, output ready);
endinterface

[design/ssd_cfg_if.sv]
// Configuration write channel.
interface ssd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ssd_pkg::CFG_ADDR_W-1:0]   addr;
    logic [ssd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[design/seven_segment_scan_driver.sv]
// Scan driver top level: takes one tick or write per cycle while the result path is not stalled.
// A tick's drive word passes through the character store read register and then
// the output register. Writes yield no result.
// The store read and the scan update overlap; the next read address is taken
// from the scan pointer being updated in the same cycle.
// Synchronous reset restores the configuration defaults and clears scan state and store valid bits.
module seven_segment_scan_driver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssd_in_if.sink     i_in,
    ssd_out_if.source  o_out,
    ssd_cfg_if.sink    i_cfg
);

    logic [ssd_pkg::COUNT_W-1:0] r_digit_count;
    logic                        r_active_low;
    logic [ssd_pkg::DWELL_W-1:0] r_dwell_ticks;

    logic [ssd_pkg::PTR_W-1:0]   r_rp,    n_rp;
    logic                        r_dot,   n_dot;
    logic [ssd_pkg::COUNT_W-1:0] r_slot,  n_slot;
    logic [ssd_pkg::DWELL_W-1:0] r_dwell, n_dwell;

    logic                        r_s1_valid;
    logic                        r_out_valid;
    logic [ssd_pkg::LINE_W-1:0]  r_common;
    logic [ssd_pkg::LINE_W-1:0]  r_segment;
    logic                        r_pass_end;

    ssd_pkg::t_wr_req wr;
    ssd_pkg::t_rd_req rd;
    ssd_pkg::t_rd_rsp rsp;

    logic                        in_xfer;
    logic                        s1_move;
    logic [ssd_pkg::COUNT_W-1:0] eff_n;
    logic [ssd_pkg::COUNT_W-1:0] total;
    logic [ssd_pkg::LINE_W:0]    wired_ext;
    logic [ssd_pkg::LINE_W-1:0]  wired;
    logic [ssd_pkg::LINE_W-1:0]  sel;
    logic [ssd_pkg::LINE_W-1:0]  com;
    logic [ssd_pkg::LINE_W-1:0]  code;
    logic [ssd_pkg::LINE_W-1:0]  seg;
    logic [ssd_pkg::CHAR_W-1:0]  disp;
    logic                        frame_end;
    logic                        pend;
    logic [ssd_pkg::COUNT_W-1:0] slot_inc;
    logic [ssd_pkg::PTR_W-1:0]   t_rp;
    logic                        t_dot;
    logic [ssd_pkg::COUNT_W-1:0] t_slot;
    logic [ssd_pkg::DWELL_W-1:0] t_dwell;

    assign eff_n = (r_digit_count > ssd_pkg::COUNT_W'(ssd_pkg::MAX_DIGITS))
                 ? ssd_pkg::COUNT_W'(ssd_pkg::MAX_DIGITS) : r_digit_count;
    assign total = eff_n + ssd_pkg::COUNT_W'(ssd_pkg::EXTRA_SLOTS);

    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Drive word for the tick held in the second stage.
    always_comb begin
        wired_ext = (ssd_pkg::LINE_W+1)'(1) << eff_n;
        wired_ext = wired_ext - (ssd_pkg::LINE_W+1)'(1);
        wired     = wired_ext[ssd_pkg::LINE_W-1:0];
        sel       = (r_slot < eff_n)
                  ? (ssd_pkg::LINE_W'(1) << r_slot[$clog2(ssd_pkg::LINE_W)-1:0]) : '0;
        com       = r_active_low ? (~sel & wired) : (sel & wired);
        disp      = r_dot ? rsp.char1 : rsp.char0;
        code      = ssd_pkg::seg_lookup(disp);
        seg       = r_active_low ? code : ~code;
    end

    // Scan state after the second-stage tick.
    always_comb begin
        frame_end = r_dwell >= r_dwell_ticks;
        t_rp      = r_rp;
        t_dot     = r_dot;
        t_slot    = r_slot;
        t_dwell   = r_dwell + ssd_pkg::DWELL_W'(1);
        pend      = 1'b0;
        slot_inc  = r_slot + ssd_pkg::COUNT_W'(1);
        if (frame_end) begin
            t_dwell = '0;
            if (!r_dot && rsp.char1 == ssd_pkg::CHAR_DOT && rsp.char0 != ssd_pkg::CHAR_DOT) begin
                t_dot = 1'b1;
            end else begin
                t_rp  = r_rp + ssd_pkg::PTR_W'(1) + ssd_pkg::PTR_W'(r_dot);
                t_dot = 1'b0;
                if (slot_inc >= total) begin
                    t_slot = '0;
                    t_rp   = '0;
                    pend   = 1'b1;
                end else begin
                    t_slot = slot_inc;
                end
            end
        end
        n_rp    = s1_move ? t_rp    : r_rp;
        n_dot   = s1_move ? t_dot   : r_dot;
        n_slot  = s1_move ? t_slot  : r_slot;
        n_dwell = s1_move ? t_dwell : r_dwell;
    end

    // A new tick reads at the pointer as it stands after the tick ahead of it.
    always_comb begin
        wr.en    = in_xfer && !i_in.cmd;
        wr.pos   = i_in.position;
        wr.data  = i_in.char_code;
        rd.en    = in_xfer && i_in.cmd;
        rd.addr0 = ssd_pkg::RD_AW'(n_rp);
        rd.addr1 = ssd_pkg::RD_AW'(n_rp) + ssd_pkg::RD_AW'(1);
    end

    ssd_char_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_total (total),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= ssd_pkg::RESET_DIGITS;
            r_active_low  <= 1'b1;
            r_dwell_ticks <= ssd_pkg::RESET_DWELL;
        end else if (i_cfg.valid) begin
            case (ssd_pkg::t_cfg_addr'(i_cfg.addr))
                ssd_pkg::CFG_DIGIT_COUNT: r_digit_count <= i_cfg.data[ssd_pkg::COUNT_W-1:0];
                ssd_pkg::CFG_ACTIVE_LOW:  r_active_low  <= i_cfg.data[0];
                ssd_pkg::CFG_DWELL_TICKS: r_dwell_ticks <= i_cfg.data[ssd_pkg::DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_dot       <= 1'b0;
            r_slot      <= '0;
            r_dwell     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rp    <= n_rp;
            r_dot   <= n_dot;
            r_slot  <= n_slot;
            r_dwell <= n_dwell;
            if (rd.en) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_common   <= com;
            r_segment  <= seg;
            r_pass_end <= pend;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.common_lines  = r_common;
    assign o_out.segment_lines = r_segment;
    assign o_out.pass_end      = r_pass_end;

endmodule

[design/ssd_char_store.sv]
// Character store: one write port, two registered read ports, reset-cleared by valid bits.
module ssd_char_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ssd_pkg::COUNT_W-1:0]   i_total,
    input  ssd_pkg::t_wr_req              i_wr,
    input  ssd_pkg::t_rd_req              i_rd,
    output ssd_pkg::t_rd_rsp              o_rsp
);

    logic [ssd_pkg::CHAR_W-1:0] mem [ssd_pkg::STORE_DEPTH];
    logic [ssd_pkg::STORE_DEPTH-1:0] r_valid;

    logic [ssd_pkg::CHAR_W-1:0] r_data0;
    logic [ssd_pkg::CHAR_W-1:0] r_data1;
    logic                       r_hit0;
    logic                       r_hit1;

    logic                            wr_ok;
    logic                            in0;
    logic                            in1;
    logic [ssd_pkg::STORE_AW-1:0]    idx0;
    logic [ssd_pkg::STORE_AW-1:0]    idx1;
    logic [ssd_pkg::STORE_AW-1:0]    widx;

    // The slot count never exceeds the store depth, so in range implies a legal index.
    assign wr_ok = i_wr.en && (i_wr.pos < i_total);
    assign widx  = ssd_pkg::STORE_AW'(i_wr.pos);
    assign in0   = i_rd.addr0 < ssd_pkg::RD_AW'(i_total);
    assign in1   = i_rd.addr1 < ssd_pkg::RD_AW'(i_total);
    assign idx0  = i_rd.addr0[ssd_pkg::STORE_AW-1:0];
    assign idx1  = i_rd.addr1[ssd_pkg::STORE_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[widx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_data0 <= mem[idx0];
            r_data1 <= mem[idx1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit0  <= 1'b0;
            r_hit1  <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_valid[widx] <= 1'b1;
            end
            if (i_rd.en) begin
                r_hit0 <= in0 && r_valid[idx0];
                r_hit1 <= in1 && r_valid[idx1];
            end
        end
    end

    assign o_rsp.char0 = r_hit0 ? r_data0 : '0;
    assign o_rsp.char1 = r_hit1 ? r_data1 : '0;

endmodule

[design/ssd_checker.sv]
// Port-level checker for the scan driver, bound to the top level.
`include "seven_segment_scan_driver_macros.svh"

module ssd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssd_in_if.sink     i_in,
    ssd_out_if.source  o_out,
    ssd_cfg_if.sink    i_cfg
);

    logic [ssd_pkg::COUNT_W-1:0] r_digit_count;
    logic                        r_active_low;
    logic [1:0]                  r_pending;

    logic                        tick_xfer;
    logic                        out_xfer;
    logic                        shown;
    logic                        stalled;
    logic [2*ssd_pkg::LINE_W+1:0] held;
    logic [ssd_pkg::COUNT_W-1:0] eff_n;
    logic [ssd_pkg::LINE_W:0]    wired_ext;
    logic [ssd_pkg::LINE_W-1:0]  wired;
    logic [ssd_pkg::LINE_W-1:0]  selected;
    logic [ssd_pkg::LINE_W-1:0]  stray;

    assign tick_xfer = i_in.valid && i_in.ready && i_in.cmd;
    assign out_xfer  = o_out.valid && o_out.ready;
    assign shown     = o_out.valid;
    assign stalled   = o_out.valid && !o_out.ready;
    // Valid is part of the held word, so a stalled result must also stay valid.
    assign held      = {o_out.valid, o_out.common_lines, o_out.segment_lines, o_out.pass_end};
    assign eff_n     = (r_digit_count > ssd_pkg::COUNT_W'(ssd_pkg::MAX_DIGITS))
                     ? ssd_pkg::COUNT_W'(ssd_pkg::MAX_DIGITS) : r_digit_count;
    assign wired_ext = ((ssd_pkg::LINE_W+1)'(1) << eff_n) - (ssd_pkg::LINE_W+1)'(1);
    assign wired     = wired_ext[ssd_pkg::LINE_W-1:0];
    assign selected  = r_active_low ? (~o_out.common_lines & wired) : o_out.common_lines;
    assign stray     = o_out.common_lines & ~wired;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= ssd_pkg::RESET_DIGITS;
            r_active_low  <= 1'b1;
            r_pending     <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (ssd_pkg::t_cfg_addr'(i_cfg.addr) == ssd_pkg::CFG_DIGIT_COUNT) begin
                    r_digit_count <= i_cfg.data[ssd_pkg::COUNT_W-1:0];
                end
                if (ssd_pkg::t_cfg_addr'(i_cfg.addr) == ssd_pkg::CFG_ACTIVE_LOW) begin
                    r_active_low <= i_cfg.data[0];
                end
            end
            r_pending <= r_pending + 2'(tick_xfer) - 2'(out_xfer);
        end
    end

    `SSD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stalled, $stable(held), "result not held")
    `SSD_ASSERT_NOW(a_one_digit, i_clk, i_rst_n, shown, $onehot0(selected), "two digits selected")
    `SSD_ASSERT_NOW(a_unwired_low, i_clk, i_rst_n, shown, stray == '0, "unwired common driven")
    `SSD_ASSERT_NOW(a_has_tick, i_clk, i_rst_n, shown, r_pending != 2'd0, "result without a tick")

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .i_cfg   (i_cfg)
);
